/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SVA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SVA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SVA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SVA_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* rtl/ipq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipq_pkg
// shared types and constants of the dotted-quad parser
// ---------------------------------------------------------------------------
package ipq_pkg;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [8:0] OCTET_SAT   = 9'd256;
    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [2:0] COUNT_SAT   = 3'd7;
    localparam logic [2:0] MIN_CHARS   = 3'd7;
    localparam logic [2:0] DOTS_NEEDED = 3'd3;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } ipq_item_t;

endpackage

/* rtl/ipq_in_stage.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipq_in_stage
// input register holding one character item for the step logic
// ---------------------------------------------------------------------------
module ipq_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ipq_pkg::ipq_item_t in_item,
    output logic               s_valid,
    output ipq_pkg::ipq_item_t s_item,
    input  logic               s_take
);
    import ipq_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ipq_item_t item_reg;

    assign in_ready   = !valid_reg || s_take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !s_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign s_valid = valid_reg;
    assign s_item  = item_reg;

endmodule

/* rtl/ipq_step.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// ipq_step
// per-character parse state update and result register
// ---------------------------------------------------------------------------
module ipq_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mask_mode,
    input  logic               s_valid,
    input  ipq_pkg::ipq_item_t s_item,
    output logic               s_take,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               valid_res,
    output logic [31:0]        address
);
    import ipq_pkg::*;

    logic [2:0]  char_count_reg, char_count_next;
    logic [2:0]  dot_count_reg, dot_count_next;
    logic        bad_char_reg, bad_char_next;
    logic [8:0]  octet_value_reg, octet_value_next;
    logic        octet_overflow_reg, octet_overflow_next;
    logic [31:0] address_acc_reg, address_acc_next;
    logic        out_valid_reg, out_valid_next;
    logic        valid_res_reg, valid_res_next;
    logic [31:0] address_reg, address_next;

    logic        is_dot;
    logic        is_digit;
    logic [7:0]  digit_full;
    logic [11:0] octet_ext;
    logic [11:0] octet_prod;
    logic [2:0]  cc1, dc1;
    logic        bad1;
    logic [8:0]  oct1;
    logic        ovf1, ovf2;
    logic [31:0] acc1, acc2;
    logic        parse_ok;
    logic [31:0] addr_res;
    logic [31:0] inv_addr;
    logic        mask_ok;
    logic        load;

    assign s_take = s_valid && (!s_item.last_char || !out_valid_reg || out_ready);
    assign load   = s_take && s_item.last_char;

    always_comb
    begin
        is_dot     = (s_item.character == CHAR_DOT);
        is_digit   = (s_item.character >= CHAR_ZERO) && (s_item.character <= CHAR_NINE);
        digit_full = s_item.character - CHAR_ZERO;
        octet_ext  = {3'b000, octet_value_reg};
        octet_prod = (octet_ext << 3) + (octet_ext << 1) + {8'd0, digit_full[3:0]};

        cc1  = (char_count_reg < COUNT_SAT) ? char_count_reg + 3'd1 : char_count_reg;
        dc1  = dot_count_reg;
        bad1 = bad_char_reg;
        oct1 = octet_value_reg;
        ovf1 = octet_overflow_reg;
        acc1 = address_acc_reg;
        if (is_dot)
        begin
            dc1  = (dot_count_reg < COUNT_SAT) ? dot_count_reg + 3'd1 : dot_count_reg;
            ovf1 = octet_overflow_reg | octet_value_reg[8];
            acc1 = {address_acc_reg[23:0], octet_value_reg[7:0]};
            oct1 = 9'd0;
        end
        else if (is_digit)
        begin
            oct1 = (octet_prod > OCTET_MAX) ? OCTET_SAT : octet_prod[8:0];
        end
        else
        begin
            bad1 = 1'b1;
        end

        // final octet close on the last character
        ovf2     = ovf1 | oct1[8];
        acc2     = {acc1[23:0], oct1[7:0]};
        parse_ok = (cc1 >= MIN_CHARS) && !bad1 && (dc1 == DOTS_NEEDED) && !ovf2;
        addr_res = parse_ok ? acc2 : 32'd0;
        inv_addr = ~addr_res;
        mask_ok  = ((inv_addr & (inv_addr + 32'd1)) == 32'd0);
    end

    always_comb
    begin
        char_count_next     = char_count_reg;
        dot_count_next      = dot_count_reg;
        bad_char_next       = bad_char_reg;
        octet_value_next    = octet_value_reg;
        octet_overflow_next = octet_overflow_reg;
        address_acc_next    = address_acc_reg;
        if (s_take)
        begin
            if (s_item.last_char)
            begin
                char_count_next     = 3'd0;
                dot_count_next      = 3'd0;
                bad_char_next       = 1'b0;
                octet_value_next    = 9'd0;
                octet_overflow_next = 1'b0;
                address_acc_next    = 32'd0;
            end
            else
            begin
                char_count_next     = cc1;
                dot_count_next      = dc1;
                bad_char_next       = bad1;
                octet_value_next    = oct1;
                octet_overflow_next = ovf1;
                address_acc_next    = acc1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        valid_res_next = valid_res_reg;
        address_next   = address_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            valid_res_next = parse_ok && (!mask_mode || mask_ok);
            address_next   = addr_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg     <= 3'd0;
            dot_count_reg      <= 3'd0;
            bad_char_reg       <= 1'b0;
            octet_value_reg    <= 9'd0;
            octet_overflow_reg <= 1'b0;
            address_acc_reg    <= 32'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            char_count_reg     <= char_count_next;
            dot_count_reg      <= dot_count_next;
            bad_char_reg       <= bad_char_next;
            octet_value_reg    <= octet_value_next;
            octet_overflow_reg <= octet_overflow_next;
            address_acc_reg    <= address_acc_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg <= valid_res_next;
        address_reg   <= address_next;
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign address   = address_reg;

    `SVA_ASSERT(a_clear_after_last, clk, rst_n, load |=> (char_count_reg == 3'd0 && dot_count_reg == 3'd0 && address_acc_reg == 32'd0), "parse state not cleared after last item")
    `SVA_NEVER(a_octet_range, clk, rst_n, octet_value_reg > OCTET_SAT, "octet value beyond saturation")
    `SVA_NEVER(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready && load, "result register overwritten while stalled")
    `SVA_NEVER(a_dots_le_chars, clk, rst_n, dot_count_reg > char_count_reg, "more dots than characters")

endmodule

/* rtl/ipv4_dotted_quad_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// parses a dotted-decimal IPv4 string, one character per item, into an
// address with a validity flag, optionally checking for a contiguous mask
// ---------------------------------------------------------------------------
// channel   handshake               payload
// in        in_valid / in_ready     character, last_char
// out       out_valid / out_ready   valid_res, address
// cfg       cfg_valid / cfg_ready   mask_mode
//
// one character item accepted per cycle unless a stalled result holds back a
// last character; results pass through the input register and the result register
// reset clears the parse state, the mask mode and both stage valid flags
// a stalled result only holds back a last character; other characters keep
// flowing into the parse state behind it
// ---------------------------------------------------------------------------
module ipv4_dotted_quad_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  character,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [31:0] address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        mask_mode
);
    import ipq_pkg::*;

    ipq_item_t in_item;
    ipq_item_t s_item;
    logic      s_valid;
    logic      s_take;
    logic      mask_mode_reg;
    logic      mask_mode_next;

    assign in_item.character = character;
    assign in_item.last_char = last_char;

    assign cfg_ready      = 1'b1;
    assign mask_mode_next = (cfg_valid && cfg_ready) ? mask_mode : mask_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_mode_reg <= 1'b0;
        end
        else
        begin
            mask_mode_reg <= mask_mode_next;
        end
    end

    ipq_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .s_valid  (s_valid),
        .s_item   (s_item),
        .s_take   (s_take)
    );

    ipq_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .mask_mode (mask_mode_reg),
        .s_valid   (s_valid),
        .s_item    (s_item),
        .s_take    (s_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .address   (address)
    );

endmodule

/* sim/ipv4_dotted_quad_parser_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipv4_dotted_quad_parser_test
// feeds dotted-decimal strings one character item at a time: a table of
// directed strings first, then random strings grouped in phases that
// alternate the mask mode. every result is checked against a local parse
// of the same characters or against a typed row of the table, with random
// gaps on the input and random stalls on the output
// ---------------------------------------------------------------------------
module ipv4_dotted_quad_parser_test;

    import ipq_pkg::*;

    localparam int TOTAL_ITEMS = 1550;
    localparam int QUIET_ITEMS = 200;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
    } parse_result_t;

    typedef struct packed {
        logic [127:0] text;
        logic         last;
        logic         mode;
        logic         typed;
        logic         exp_valid;
        logic [31:0]  exp_addr;
    } directed_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  character = 8'h30;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic        valid_res;
    logic [31:0] address;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_mask = 1'b0;

    // local copy of the parse state and the mask setting
    logic        mask_check = 1'b0;
    logic [2:0]  seen_chars = '0;
    logic [2:0]  seen_dots = '0;
    logic        saw_bad = 1'b0;
    logic        saw_overflow = 1'b0;
    logic [8:0]  octet_acc = '0;
    logic [31:0] address_acc = '0;

    parse_result_t expected_results[$];
    logic [7:0]    pending_chars[$];

    int          errors = 0;
    int          sent_items = 0;
    int          gap_percent = 0;
    int          stall_percent = 0;
    int          stall_left = 0;
    logic        quiet = 1'b0;

    directed_row_t directed_rows [0:18] = '{
        '{"0.0.0.0",         1'b1, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
        '{"255.255.255.255", 1'b1, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{"1..3.4",          1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{"256.0.0.1",       1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{"1.2.3.4.5",       1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{"1.2.a.4",         1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{"\001.2.3.\377",   1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{"99999.1.1.1",     1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{"........",        1'b1, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{"10..2.3",         1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
        '{"007.08.9.010",    1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
        '{"1.2",             1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
        '{".3.4",            1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
        '{"255.255.0.0",     1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_0000},
        '{"255.0.255.0",     1'b1, 1'b1, 1'b1, 1'b0, 32'hFF00_FF00},
        '{"0.0.0.0",         1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        '{"255.255.255.255", 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{"1.2.3",           1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
        '{"255.255.255.128", 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FF80}
    };

    ipv4_dotted_quad_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .character (character),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .address   (address),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .mask_mode (cfg_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void shift_octet();
        if (octet_acc > 9'd255)
            saw_overflow = 1'b1;
        address_acc = {address_acc[23:0], octet_acc[7:0]};
        octet_acc = '0;
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic l);
        logic [11:0]   next_octet;
        logic [31:0]   holes;
        parse_result_t r;
        if (seen_chars != COUNT_SAT)
            seen_chars = seen_chars + 3'd1;
        if (c == CHAR_DOT)
        begin
            if (seen_dots != COUNT_SAT)
                seen_dots = seen_dots + 3'd1;
            shift_octet();
        end
        else if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            next_octet = 12'(octet_acc) * 12'd10 + 12'(c - CHAR_ZERO);
            octet_acc = (next_octet > OCTET_MAX) ? OCTET_SAT : next_octet[8:0];
        end
        else
            saw_bad = 1'b1;
        if (l)
        begin
            shift_octet();
            r.valid_res = (seen_chars >= MIN_CHARS) && !saw_bad &&
                          (seen_dots == DOTS_NEEDED) && !saw_overflow;
            r.address = r.valid_res ? address_acc : 32'h0;
            holes = ~r.address;
            if (r.valid_res && mask_check && (holes & (holes + 32'd1)) != 32'h0)
                r.valid_res = 1'b0;
            expected_results.push_back(r);
            seen_chars = '0;
            seen_dots = '0;
            saw_bad = 1'b0;
            saw_overflow = 1'b0;
            octet_acc = '0;
            address_acc = '0;
        end
    endfunction

    function automatic void push_octet(input int unsigned v);
        logic [7:0] digits[$];
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) pending_chars.push_back(CHAR_ZERO);
        do
        begin
            digits.push_front(CHAR_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digits[i])
            pending_chars.push_back(digits[i]);
    endfunction

    // mostly four-field strings, some corrupted, some with the wrong field
    // count, and some plain noise
    function automatic void build_string(input logic want_mask);
        int unsigned kind;
        int unsigned fields;
        int unsigned pick;
        int unsigned pos;
        logic [31:0] quad;
        pending_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 85)
        begin
            fields = (kind < 70) ? 4 : $urandom_range(1, 9);
            if (want_mask && $urandom_range(0, 1) == 0)
            begin
                pick = $urandom_range(0, 32);
                quad = (pick == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - pick);
                if ($urandom_range(0, 5) == 0)
                    quad = quad ^ (32'd1 << $urandom_range(0, 31));
            end
            else
                quad = $urandom();
            for (int f = 0; f < fields; f++)
            begin
                if (f != 0)
                    pending_chars.push_back(CHAR_DOT);
                pick = $urandom_range(0, 29);
                case (pick)
                    0: ;
                    1: push_octet($urandom_range(256, 999));
                    2: push_octet($urandom_range(1000, 99999));
                    3: push_octet(255);
                    4: push_octet(0);
                    default: push_octet(quad[31 - 8 * (f % 4) -: 8]);
                endcase
            end
            if (kind >= 60 && kind < 70)
            begin
                pos = $urandom_range(0, pending_chars.size() - 1);
                case ($urandom_range(0, 2))
                    0: pending_chars[pos] = 8'($urandom_range(1, 255));
                    1: pending_chars.delete(pos);
                    default: pending_chars.insert(pos, CHAR_DOT);
                endcase
            end
        end
        else
        begin
            repeat ($urandom_range(1, 20))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    pending_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                else if (pick < 6)
                    pending_chars.push_back(CHAR_DOT);
                else
                    pending_chars.push_back(8'($urandom_range(1, 255)));
            end
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic l);
        if (!quiet && $urandom_range(0, 99) < gap_percent)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        character <= c;
        last_char <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_char(c, l);
        sent_items++;
        quiet = (sent_items >= TOTAL_ITEMS - QUIET_ITEMS);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input logic v);
        cfg_valid <= 1'b1;
        cfg_mask <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mask_check = v;
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (!quiet && rst_n && $urandom_range(0, 99) < stall_percent)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual valid_res %0b address %h",
                         $time, valid_res, address);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (valid_res !== want.valid_res)
                begin
                    $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                             $time, want.valid_res, valid_res);
                    errors++;
                end
                if (address !== want.address)
                begin
                    $display("%0t: address mismatch, expected %h, actual %h",
                             $time, want.address, address);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned   phase;
        int            phase_items;
        logic          close_it;
        parse_result_t typed_result;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mask(1'b0);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].mode != mask_check)
            begin
                wait_idle();
                write_mask(directed_rows[r].mode);
            end
            pending_chars.delete();
            for (int b = 15; b >= 0; b--)
                if (directed_rows[r].text[b * 8 +: 8] != 8'h00)
                    pending_chars.push_back(directed_rows[r].text[b * 8 +: 8]);
            foreach (pending_chars[i])
                send_char(pending_chars[i],
                          directed_rows[r].last && i == pending_chars.size() - 1);
            if (directed_rows[r].last && directed_rows[r].typed)
            begin
                typed_result = {directed_rows[r].exp_valid, directed_rows[r].exp_addr};
                void'(expected_results.pop_back());
                expected_results.push_back(typed_result);
            end
        end

        phase = 0;
        while (sent_items < TOTAL_ITEMS)
        begin
            phase_items = sent_items + $urandom_range(150, 250);
            if (phase_items > TOTAL_ITEMS)
                phase_items = TOTAL_ITEMS;
            wait_idle();
            write_mask(phase[0]);
            case ($urandom_range(0, 2))
                0: gap_percent = 0;
                1: gap_percent = 8;
                default: gap_percent = 25;
            endcase
            case ($urandom_range(0, 2))
                0: stall_percent = 0;
                1: stall_percent = 8;
                default: stall_percent = 25;
            endcase
            // an unterminated string runs on into the next one
            do
            begin
                build_string(mask_check);
                close_it = (sent_items + pending_chars.size() >= phase_items) ||
                           ($urandom_range(0, 9) != 0);
                foreach (pending_chars[i])
                    send_char(pending_chars[i], close_it && i == pending_chars.size() - 1);
            end
            while (!close_it || sent_items < phase_items);
            phase++;
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
